FILE: src/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared types and constants for the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WID_W     = 11;
   localparam int HGT_W     = 16;
   localparam int PIX_W     = 24;
   localparam int GRAD_W    = 11;
   localparam int SQ4_W     = 23;
   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

   localparam logic [WID_W-1:0] RESET_WIDTH  = 11'd640;
   localparam logic [HGT_W-1:0] RESET_HEIGHT = 16'd480;

   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam logic ITEM_PIXEL = 1'b0;
   localparam logic ITEM_FLUSH = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } sem_req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       out_last;
   } sem_rsp_type;

   typedef struct packed {
      logic [WID_W-1:0] width;
      logic [HGT_W-1:0] height;
      logic             restart;
   } sem_cfg_type;

   typedef struct packed {
      logic                  last;
      logic [2:0][GRAD_W-1:0] gx;
      logic [2:0][GRAD_W-1:0] gy;
   } sem_job_type;

endpackage

FILE: src/sem_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module sem_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/sem_front.sv
// ----------------------------------------------------------------------------
// Sobel front end
// Accepts pixels, keeps the line stores and window, and forms the gradients.
// ----------------------------------------------------------------------------
module sem_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  sem_pkg::sem_req_type req_data,
   input  sem_pkg::sem_cfg_type cfg,
   output logic                 q_push,
   output sem_pkg::sem_job_type q_data,
   input  logic                 q_full
);
   import sem_pkg::*;

   typedef enum logic [1:0] {
      F_IDLE   = 2'b01,
      F_ACCESS = 2'b10
   } front_state_type;

   front_state_type state_ff, state_in;
   sem_req_type     item_ff, item_in;
   logic [COL_W-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [HGT_W:0]   in_row_ff, in_row_in;
   logic [HGT_W-1:0] out_row_ff, out_row_in;
   logic [2:0][2:0][PIX_W-1:0] win_ff, win_in, win_sh;
   logic [PIX_W-1:0] upper_rd, lower_rd, pix, top, mid;
   logic             accept, access, emit, last, left_ok, right_ok;

   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock(clock), .we(access), .waddr(in_col_ff), .wdata(lower_rd),
      .raddr(in_col_ff), .rdata(upper_rd)
   );

   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
      .clock(clock), .we(access), .waddr(in_col_ff), .wdata(pix),
      .raddr(in_col_ff), .rdata(lower_rd)
   );

   assign full   = (state_ff != F_IDLE) || q_full;
   assign accept = push && !full;
   assign access = (state_ff == F_ACCESS);

   always_comb begin
      logic [9:0] sum_l, sum_r, sum_t, sum_b;
      logic [7:0] v [3][3];
      pix = ((item_ff.req_type == ITEM_PIXEL) && (in_row_ff < {1'b0, cfg.height})) ?
            {item_ff.in_red, item_ff.in_green, item_ff.in_blue} : '0;
      top = (in_row_ff >= 17'd2) ? upper_rd : '0;
      mid = (in_row_ff >= 17'd1) ? lower_rd : '0;
      for (int r = 0; r < 3; r++) begin
         win_sh[r][0] = win_ff[r][1];
         win_sh[r][1] = win_ff[r][2];
      end
      win_sh[0][2] = top;
      win_sh[1][2] = mid;
      win_sh[2][2] = pix;
      left_ok  = (out_col_ff != '0);
      right_ok = ({1'b0, out_col_ff} + 11'd1) < cfg.width;
      for (int ch = 0; ch < 3; ch++) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               v[r][c] = win_sh[r][c][ch*8 +: 8];
            end
         end
         if (!left_ok) begin
            v[0][0] = '0;
            v[1][0] = '0;
            v[2][0] = '0;
         end
         if (!right_ok) begin
            v[0][2] = '0;
            v[1][2] = '0;
            v[2][2] = '0;
         end
         sum_l = {2'b0, v[0][0]} + {1'b0, v[1][0], 1'b0} + {2'b0, v[2][0]};
         sum_r = {2'b0, v[0][2]} + {1'b0, v[1][2], 1'b0} + {2'b0, v[2][2]};
         sum_t = {2'b0, v[0][0]} + {1'b0, v[0][1], 1'b0} + {2'b0, v[0][2]};
         sum_b = {2'b0, v[2][0]} + {1'b0, v[2][1], 1'b0} + {2'b0, v[2][2]};
         q_data.gx[ch] = {1'b0, sum_r} - {1'b0, sum_l};
         q_data.gy[ch] = {1'b0, sum_b} - {1'b0, sum_t};
      end
      emit = ((in_col_ff != '0) && (in_row_ff >= 17'd1)) ||
             ((in_col_ff == '0) && (in_row_ff >= 17'd2));
      last = (({1'b0, out_row_ff} + 17'd1) >= {1'b0, cfg.height}) && !right_ok;
      q_data.last = last;
      q_push = access && emit;
   end

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      win_in     = win_ff;
      if (accept) begin
         item_in  = req_data;
         state_in = F_ACCESS;
      end
      if (access) begin
         state_in = F_IDLE;
         win_in   = win_sh;
         if (({1'b0, in_col_ff} + 11'd1) >= cfg.width) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 17'd1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
         if (emit) begin
            if (!right_ok) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 16'd1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end
      if (cfg.restart || (q_push && last)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         win_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         win_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         win_ff     <= win_in;
      end
      item_ff <= item_in;
   end

endmodule

FILE: src/sem_queue.sv
// ----------------------------------------------------------------------------
// Gradient queue
// Short queue of gradient jobs between the front end and the root unit.
// ----------------------------------------------------------------------------
module sem_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sem_pkg::sem_job_type wdata,
   output logic                 q_full,
   input  logic                 pop,
   output sem_pkg::sem_job_type rdata,
   output logic                 q_empty
);
   import sem_pkg::*;

   sem_job_type        entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign q_full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_push = push && !q_full;
   assign do_pop  = pop && !q_empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_full)) else $error("job pushed into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_empty)) else $error("job popped from an empty queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");
`endif

endmodule

FILE: src/sem_back.sv
// ----------------------------------------------------------------------------
// Sobel back end
// Squares the gradients, takes the rounded root bit by bit, and holds the beat.
// ----------------------------------------------------------------------------
module sem_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sem_pkg::sem_job_type q_data,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 empty,
   input  logic                 pop,
   output sem_pkg::sem_rsp_type rsp_data
);
   import sem_pkg::*;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_ROOT = 3'b010,
      B_DONE = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [2:0][SQ4_W-1:0] s4_ff, s4_in;
   logic [2:0][7:0]       n_ff, n_in;
   logic [2:0]            bit_ff, bit_in;
   logic                  last_ff, last_in, valid_ff, valid_in, load;
   sem_rsp_type           rsp_ff, rsp_in;

   assign empty    = !valid_ff;
   assign rsp_data = rsp_ff;
   assign load     = (state_ff == B_DONE) && (!valid_ff || pop);

   always_comb begin
      logic signed [2*GRAD_W-1:0] sqx, sqy;
      logic signed [2*GRAD_W:0]   sum;
      logic [7:0]                 cand;
      logic [8:0]                 d;
      logic [17:0]                dd;
      sqx      = '0;
      sqy      = '0;
      sum      = '0;
      cand     = '0;
      d        = '0;
      dd       = '0;
      state_in = state_ff;
      s4_in    = s4_ff;
      n_in     = n_ff;
      bit_in   = bit_ff;
      last_in  = last_ff;
      rsp_in   = rsp_ff;
      q_pop    = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               for (int ch = 0; ch < 3; ch++) begin
                  sqx = $signed(q_data.gx[ch]) * $signed(q_data.gx[ch]);
                  sqy = $signed(q_data.gy[ch]) * $signed(q_data.gy[ch]);
                  sum = sqx + sqy;
                  s4_in[ch] = {sum[SQ4_W-3:0], 2'b00};
               end
               n_in     = '0;
               bit_in   = 3'd7;
               last_in  = q_data.last;
               state_in = B_ROOT;
            end
         end
         B_ROOT: begin
            for (int ch = 0; ch < 3; ch++) begin
               cand = n_ff[ch] | (8'd1 << bit_ff);
               d    = {cand, 1'b0} - 9'd1;
               dd   = d * d;
               if ({5'b0, dd} <= s4_ff[ch]) begin
                  n_in[ch] = cand;
               end
            end
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (load) begin
               rsp_in.out_red   = n_ff[2];
               rsp_in.out_green = n_ff[1];
               rsp_in.out_blue  = n_ff[0];
               rsp_in.out_last  = last_ff;
               state_in         = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      valid_in = load ? 1'b1 : (pop ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      s4_ff   <= s4_in;
      n_ff    <= n_in;
      bit_ff  <= bit_in;
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
   end

endmodule

FILE: src/sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude, RGB
// Streaming 3x3 Sobel gradient magnitude per colour channel.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and each result is the rounded, clamped gradient
// magnitude of the pixel one row and one column behind; send image_width+1
// flush beats after the image. The front end accepts a beat in its idle state
// and reads the line stores in its access state. The root unit finds eight bits
// one per cycle and takes no new job until its result is loaded for output.
// Register writes restart the frame.
module sobel_edge_magnitude_rgb (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  sem_pkg::sem_req_type req_data,
   output logic                 empty,
   input  logic                 pop,
   output sem_pkg::sem_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [15:0]          csr_data
);
   import sem_pkg::*;

   logic [WID_W-1:0] width_ff, width_in;
   logic [HGT_W-1:0] height_ff, height_in;
   sem_cfg_type      cfg;
   sem_job_type      job_push, job_head;
   logic             q_push, q_full, q_pop, q_empty, csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_data[WID_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_data;
            default:          width_in  = width_ff;
         endcase
      end
      if (width_ff == '0) begin
         cfg.width = WID_W'(1);
      end else if (width_ff > WID_W'(MAX_WIDTH)) begin
         cfg.width = WID_W'(MAX_WIDTH);
      end else begin
         cfg.width = width_ff;
      end
      cfg.height  = (height_ff == '0) ? HGT_W'(1) : height_ff;
      cfg.restart = csr_write;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   sem_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .cfg(cfg), .q_push(q_push), .q_data(job_push), .q_full(q_full)
   );

   sem_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .wdata(job_push), .q_full(q_full),
      .pop(q_pop), .rdata(job_head), .q_empty(q_empty)
   );

   sem_back u_back (
      .clock(clock), .reset(reset), .q_data(job_head), .q_empty(q_empty),
      .q_pop(q_pop), .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

endmodule

FILE: test/tb_sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude RGB testbench
// Streams RGB images through the block under a range of image geometries and
// checks every result beat against an in-bench prediction of the line stores,
// the 3x3 window, the Sobel gradients and the rounded, clamped magnitude.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_rgb;
   timeunit 1ns;
   timeprecision 1ps;

   import sem_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   sem_req_type req_data = '0;
   logic        empty;
   logic        pop = 1'b0;
   sem_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [15:0] csr_data = '0;

   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES  = 300;

   sem_rsp_type expected_pixels[$];
   int          error_count = 0;
   int          beats_sent = 0;
   bit          quiet = 1'b0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;
   int          stall_left = 0;

   int unsigned    frame_width, frame_height;
   logic [23:0]    upper_store[MAX_WIDTH];
   logic [23:0]    lower_store[MAX_WIDTH];
   logic [23:0]    win[3][3];
   int unsigned    in_col, in_row, out_col, out_row;

   localparam int KX[3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
   localparam int KY[3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};

   sobel_edge_magnitude_rgb i_dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   initial begin
      #2000000;
      $display("sobel_edge_magnitude_rgb verification failed");
      $finish;
   end

   function automatic void restart_frame();
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            win[r][c] = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   function automatic int unsigned active_width();
      if (frame_width == 0) return 1;
      if (frame_width > MAX_WIDTH) return MAX_WIDTH;
      return frame_width;
   endfunction

   function automatic logic [7:0] channel_magnitude(int shift, bit left_ok, bit right_ok);
      int gx, gy, v, q, n;
      gx = 0;
      gy = 0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if ((c == 0 && !left_ok) || (c == 2 && !right_ok)) continue;
            v = int'((win[r][c] >> shift) & 24'hFF);
            gx += v * KX[r][c];
            gy += v * KY[r][c];
         end
      end
      q = 4 * (gx * gx + gy * gy);
      n = 0;
      while (n < 255 && (2 * n + 1) * (2 * n + 1) <= q) n++;
      return n[7:0];
   endfunction

   function automatic void predict_pixel(sem_req_type beat);
      int unsigned w, h, x, y;
      logic [23:0] pix, top, mid;
      bit          emit, left_ok, right_ok;
      sem_rsp_type res;
      w = active_width();
      h = (frame_height == 0) ? 1 : frame_height;
      x = in_col;
      y = in_row;
      pix = (beat.req_type == ITEM_PIXEL && y < h) ?
            {beat.in_red, beat.in_green, beat.in_blue} : 24'd0;
      top = (y >= 2) ? upper_store[x] : 24'd0;
      mid = (y >= 1) ? lower_store[x] : 24'd0;
      upper_store[x] = lower_store[x];
      lower_store[x] = pix;
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = pix;
      emit = (x >= 1 && y >= 1) || (x == 0 && y >= 2);
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (!emit) return;
      left_ok = out_col >= 1;
      right_ok = out_col + 1 < w;
      res.out_red = channel_magnitude(16, left_ok, right_ok);
      res.out_green = channel_magnitude(8, left_ok, right_ok);
      res.out_blue = channel_magnitude(0, left_ok, right_ok);
      res.out_last = (out_row + 1 >= h) && (out_col + 1 >= w);
      expected_pixels.push_back(res);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      if (res.out_last) restart_frame();
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   // Result side: check the accepted beat, then decide whether to stall.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_pixels.size() == 0) begin
               $display("unexpected result beat at %0t", $realtime);
               error_count++;
            end else begin
               sem_rsp_type want;
               want = expected_pixels.pop_front();
               if (rsp_data.out_red !== want.out_red)
                  report_mismatch("out_red", rsp_data.out_red, want.out_red);
               if (rsp_data.out_green !== want.out_green)
                  report_mismatch("out_green", rsp_data.out_green, want.out_green);
               if (rsp_data.out_blue !== want.out_blue)
                  report_mismatch("out_blue", rsp_data.out_blue, want.out_blue);
               if (rsp_data.out_last !== want.out_last)
                  report_mismatch("out_last", rsp_data.out_last, want.out_last);
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   task automatic send_beat(sem_req_type beat);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (full);
      predict_pixel(beat);
      beats_sent++;
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      wait (expected_pixels.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic index, logic [15:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == REG_IMAGE_WIDTH) frame_width = value & 16'h07FF;
      else frame_height = value;
      restart_frame();
   endtask

   function automatic sem_req_type make_beat(logic kind, int mode, int idx);
      sem_req_type b;
      b.req_type = kind;
      case (mode)
         1: begin
            b.in_red = (idx % 2) ? 8'hFF : 8'h00;
            b.in_green = (idx % 2) ? 8'h00 : 8'hFF;
            b.in_blue = ((idx / 2) % 2) ? 8'hFF : 8'h00;
         end
         2: begin
            b.in_red = 8'hFF;
            b.in_green = 8'hFF;
            b.in_blue = 8'hFF;
         end
         default: begin
            b.in_red = $urandom();
            b.in_green = $urandom();
            b.in_blue = $urandom();
         end
      endcase
      return b;
   endfunction

   // One image plus its flush beats; noise swaps some pixels and flushes.
   task automatic send_frame(int w, int h, int mode, int noise);
      logic kind;
      for (int i = 0; i < w * h + w + 1; i++) begin
         kind = (i < w * h) ? ITEM_PIXEL : ITEM_FLUSH;
         if (noise > 0 && $urandom_range(0, 99) < noise) kind = ~kind;
         send_beat(make_beat(kind, mode, i));
      end
   endtask

   task automatic set_geometry(int w, int h);
      write_register(REG_IMAGE_WIDTH, 16'(w));
      write_register(REG_IMAGE_HEIGHT, 16'(h));
   endtask

   task automatic test_reset_geometry();
      for (int i = 0; i < 4; i++) send_beat(make_beat(ITEM_PIXEL, 0, i));
   endtask

   task automatic test_single_pixel();
      set_geometry(1, 1);
      send_frame(1, 1, 2, 0);
      set_geometry(0, 0);
      send_frame(1, 1, 0, 0);
   endtask

   task automatic test_extreme_gradients();
      set_geometry(3, 3);
      send_frame(3, 3, 1, 0);
   endtask

   task automatic test_early_flush_and_late_pixels();
      set_geometry(2, 2);
      send_beat(make_beat(ITEM_PIXEL, 2, 0));
      send_beat(make_beat(ITEM_FLUSH, 2, 1));
      send_beat(make_beat(ITEM_PIXEL, 2, 2));
      send_beat(make_beat(ITEM_PIXEL, 2, 3));
      for (int i = 0; i < 3; i++) send_beat(make_beat(ITEM_PIXEL, 2, i));
   endtask

   task automatic test_register_limits();
      set_geometry(16'hFFFF, 16'hFFFF);
      for (int i = 0; i < 6; i++) send_beat(make_beat(ITEM_PIXEL, 0, i));
      write_register(REG_IMAGE_WIDTH, 16'h0801);
      write_register(REG_IMAGE_HEIGHT, 16'd1);
      send_frame(1, 1, 0, 0);
   endtask

   // A full row at the widest setting and the first few results behind it.
   task automatic test_widest_row();
      write_register(REG_IMAGE_WIDTH, 16'd1024);
      write_register(REG_IMAGE_HEIGHT, 16'd1);
      for (int i = 0; i < 1024 + 8; i++)
         send_beat(make_beat((i < 1024) ? ITEM_PIXEL : ITEM_FLUSH, 0, i));
   endtask

   task automatic test_back_pressure();
      set_geometry(5, 4);
      hold_request = 1'b1;
      send_frame(5, 4, 0, 0);
   endtask

   task automatic test_random_frames();
      int w, h;
      while (beats_sent < 1300) begin
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 6);
         set_geometry(w | ($urandom_range(0, 31) << 11), h);
         case ($urandom_range(0, 9))
            0: begin
               for (int i = $urandom_range(1, w * h); i > 0; i--)
                  send_beat(make_beat($urandom_range(0, 1), 0, i));
            end
            1: send_frame(w, h, 0, 10);
            default: send_frame(w, h, $urandom_range(0, 3), 0);
         endcase
      end
   endtask

   task automatic test_quiet_tail();
      quiet = 1'b1;
      set_geometry(7, 5);
      send_frame(7, 5, 0, 0);
   endtask

   initial begin
      frame_width = RESET_WIDTH;
      frame_height = RESET_HEIGHT;
      restart_frame();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_geometry();
      test_single_pixel();
      test_extreme_gradients();
      test_early_flush_and_late_pixels();
      test_register_limits();
      test_widest_row();
      test_back_pressure();
      test_random_frames();
      test_quiet_tail();
      wait_idle();
      if (error_count == 0) begin
         $display("sobel_edge_magnitude_rgb verification clean");
      end else begin
         $display("sobel_edge_magnitude_rgb verification failed");
      end
      $finish;
   end

endmodule

FILE: sobel_edge_magnitude_rgb.f
src/sem_pkg.sv
src/sem_ram.sv
src/sem_front.sv
src/sem_queue.sv
src/sem_back.sv
src/sobel_edge_magnitude_rgb.sv
test/tb_sobel_edge_magnitude_rgb.sv
